@@ rtl/ake_pkg.sv @@
// Shared types, constants and saturation helpers for the altitude estimator.
package ake_pkg;

  // Fixed 0.1 s covariance step in Q16.16
  localparam logic signed [31:0] STEP_FIXED = 32'sd6554;
  // Measurement noise ceiling, 1500.0 in Q16.16
  localparam logic [26:0] NOISE_MAX = 27'd98304000;
  // Integral bias limit, 100.0 in Q16.16
  localparam logic signed [32:0] BIAS_LIMIT = 33'sd6553600;
  // Divider iteration count: quotient bits of a Q16.16 numerator shifted by 16
  localparam logic [5:0] DIV_STEPS = 6'd48;

  // Configuration register indexes
  localparam logic [2:0] CFG_POS_NOISE = 3'd0;
  localparam logic [2:0] CFG_SPD_NOISE = 3'd1;
  localparam logic [2:0] CFG_INT_GAIN  = 3'd2;
  localparam logic [2:0] CFG_PROP_GAIN = 3'd3;

  // Datapath commands, one per sequencer step
  typedef enum logic [4:0] {
    OP_IDLE, OP_LOAD, OP_ACC, OP_M1, OP_M2, OP_M3, OP_W3, OP_M5, OP_M6, OP_W6,
    OP_DSTART, OP_DIV, OP_DFIN, OP_M7, OP_M8, OP_M9, OP_M10, OP_M11, OP_M12,
    OP_M13, OP_M14, OP_W14, OP_DONE
  } dp_op_e;

  // Datapath status back to the controller
  typedef struct packed {
    logic obs_valid;
    logic div_done;
  } dp_status_t;

  // Clamp a wide signed value into signed 32 bit
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Scale a Q16.16 product back with a floor shift and saturate
  function automatic logic signed [31:0] mulq(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> 16;
    return sat32(66'(s));
  endfunction

endpackage

@@ rtl/ake_ctrl.sv @@
// Step sequencer for the estimator: walks one tick through the shared datapath.
module ake_ctrl
  import ake_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_op_e     op_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_ACC, ST_M1, ST_M2, ST_M3, ST_W3, ST_M5, ST_M6, ST_W6, ST_DSTART,
    ST_DIV, ST_DFIN, ST_M7, ST_M8, ST_M9, ST_M10, ST_M11, ST_M12, ST_M13, ST_M14,
    ST_W14, ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_fin;

  // Finish only when the result register is free or being drained
  assign can_fin    = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and datapath command
  always_comb begin
    state_d = state_q;
    op_o    = OP_IDLE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_o    = OP_LOAD;
          state_d = ST_ACC;
        end
      end
      ST_ACC:    begin op_o = OP_ACC;    state_d = ST_M1;  end
      ST_M1:     begin op_o = OP_M1;     state_d = ST_M2;  end
      ST_M2:     begin op_o = OP_M2;     state_d = ST_M3;  end
      ST_M3:     begin op_o = OP_M3;     state_d = ST_W3;  end
      ST_W3: begin
        op_o    = OP_W3;
        state_d = status_i.obs_valid ? ST_M5 : ST_DONE;
      end
      ST_M5:     begin op_o = OP_M5;     state_d = ST_M6;  end
      ST_M6:     begin op_o = OP_M6;     state_d = ST_W6;  end
      ST_W6:     begin op_o = OP_W6;     state_d = ST_DSTART; end
      ST_DSTART: begin op_o = OP_DSTART; state_d = ST_DIV; end
      ST_DIV: begin
        op_o = OP_DIV;
        if (status_i.div_done) begin
          state_d = ST_DFIN;
        end
      end
      ST_DFIN:   begin op_o = OP_DFIN;   state_d = ST_M7;  end
      ST_M7:     begin op_o = OP_M7;     state_d = ST_M8;  end
      ST_M8:     begin op_o = OP_M8;     state_d = ST_M9;  end
      ST_M9:     begin op_o = OP_M9;     state_d = ST_M10; end
      ST_M10:    begin op_o = OP_M10;    state_d = ST_M11; end
      ST_M11:    begin op_o = OP_M11;    state_d = ST_M12; end
      ST_M12:    begin op_o = OP_M12;    state_d = ST_M13; end
      ST_M13:    begin op_o = OP_M13;    state_d = ST_M14; end
      ST_M14:    begin op_o = OP_M14;    state_d = ST_W14; end
      ST_W14:    begin op_o = OP_W14;    state_d = ST_DONE; end
      ST_DONE: begin
        if (can_fin) begin
          op_o    = OP_DONE;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result valid: set on finish, drop when the result is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == ST_DONE && can_fin) begin
      out_valid_d = 1'b1;
    end
  end

  // Hold state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/ake_datapath.sv @@
// Estimator datapath: state, shared multiplier, dual-quotient divider, history.
module ake_datapath
  import ake_pkg::*;
#(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_op_e             op_i,
  output dp_status_t         status_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic signed [31:0] accel_drive_i,
  input  logic [15:0]        step_time_i,
  input  logic signed [31:0] observation_i,
  input  logic [3:0]         delay_index_i,
  input  logic               observation_valid_i,
  input  logic [26:0]        measurement_noise_i,
  output logic signed [31:0] position_o,
  output logic signed [31:0] speed_o,
  output logic signed [31:0] corrected_accel_o,
  output logic signed [31:0] bias_total_o,
  output logic               observation_used_o
);

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  // Configuration
  logic [23:0] pos_noise_q, spd_noise_q;
  logic [15:0] int_gain_q, prop_gain_q;

  // Latched request
  logic signed [31:0] acc_q, obs_q;
  logic [15:0]        dt_q;
  logic               ov_q;
  logic [26:0]        noise_q;

  // Filter state
  logic signed [31:0] pos_q, spd_q, bi_q, bs_q;
  logic signed [31:0] cov_q [4];

  // Intermediates
  logic signed [31:0] cor_q, z_q, dv_q, a_q, c_q, t2_q, t3_q, m2_q, t0_q, k0_q, k1_q;
  logic signed [63:0] p_q;
  logic signed [31:0] mul_a, mul_b, pq;

  // Divider
  logic [5:0]  dcnt_q;
  logic [47:0] num0_q, num1_q;
  logic [34:0] rem0_q, rem1_q;
  logic [33:0] den_q;
  logic        neg0_q, neg1_q, szero_q;
  logic [34:0] trial0, trial1;
  logic        ge0, ge1;
  logic signed [33:0] s_w;

  // History
  logic signed [31:0] hmem [HISTORY_DEPTH];
  logic signed [31:0] smem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] hvalid_q;
  logic [AW-1:0]      wp_q, wp_nx, sp_q, sp_nx, raddr;
  logic               phase_q;
  logic signed [31:0] hrd_q;
  logic               hvld_q;
  logic [8:0]         dly_ext, dly_c, off, wp_ext, raddr9;

  assign pq = mulq(p_q);
  assign status_o.obs_valid = ov_q;
  assign status_o.div_done  = (dcnt_q == 6'd0);

  // History read address: newest entry minus clamped delay, modulo depth
  always_comb begin
    dly_ext = {5'd0, delay_index_i};
    dly_c   = (dly_ext > 9'(HISTORY_DEPTH - 1)) ? 9'(HISTORY_DEPTH - 1) : dly_ext;
    off     = dly_c + 9'd1;
    wp_ext  = 9'(wp_q);
    raddr9  = (wp_ext >= off) ? (wp_ext - off) : (wp_ext + 9'(HISTORY_DEPTH) - off);
    raddr   = raddr9[AW-1:0];
    wp_nx   = (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
    sp_nx   = (sp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : sp_q + AW'(1);
  end

  // Multiplier operand select
  always_comb begin
    mul_a = cor_q;
    mul_b = $signed({16'd0, dt_q});
    case (op_i)
      OP_M1:  begin mul_a = cor_q; mul_b = $signed({16'd0, dt_q}); end
      OP_M2:  begin mul_a = spd_q; mul_b = $signed({16'd0, dt_q}); end
      OP_M3:  begin mul_a = dv_q;  mul_b = $signed({16'd0, dt_q}); end
      OP_W3:  begin mul_a = cov_q[3]; mul_b = STEP_FIXED; end
      OP_M5:  begin mul_a = cov_q[2]; mul_b = STEP_FIXED; end
      OP_M6:  begin mul_a = c_q;      mul_b = STEP_FIXED; end
      OP_M7:  begin mul_a = k0_q; mul_b = z_q; end
      OP_M8:  begin mul_a = k1_q; mul_b = z_q; end
      OP_M9:  begin mul_a = $signed({16'd0, int_gain_q});  mul_b = z_q; end
      OP_M10: begin mul_a = $signed({16'd0, prop_gain_q}); mul_b = z_q; end
      OP_M11: begin mul_a = k0_q; mul_b = t0_q; end
      OP_M12: begin mul_a = k0_q; mul_b = c_q;  end
      OP_M13: begin mul_a = k1_q; mul_b = t0_q; end
      OP_M14: begin mul_a = k1_q; mul_b = c_q;  end
      default: ;
    endcase
  end

  // Divider trial subtract for both gains against the shared divisor
  always_comb begin
    trial0 = {rem0_q[33:0], num0_q[47]};
    trial1 = {rem1_q[33:0], num1_q[47]};
    ge0    = trial0 >= {1'b0, den_q};
    ge1    = trial1 >= {1'b0, den_q};
    s_w    = $signed({{2{t0_q[31]}}, t0_q}) + $signed({7'd0, noise_q});
  end

  // Saturate a signed quotient given as magnitude and sign
  function automatic logic signed [31:0] qsat(input logic [47:0] q, input logic neg,
                                              input logic zero);
    logic signed [31:0] r;
    logic [48:0]        nq;
    nq = 49'd0 - {1'b0, q};
    if (zero) begin
      r = '0;
    end else if (!neg) begin
      r = (q > 48'h0000_7fff_ffff) ? 32'sh7fffffff : $signed(q[31:0]);
    end else begin
      r = (q > 48'h0000_8000_0000) ? 32'sh80000000 : $signed(nq[31:0]);
    end
    return r;
  endfunction

  // Product register
  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_noise_q <= 24'd328;
      spd_noise_q <= 24'd6554;
      int_gain_q  <= 16'd1638;
      prop_gain_q <= 16'd1966;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_POS_NOISE: pos_noise_q <= cfg_data_i;
        CFG_SPD_NOISE: spd_noise_q <= cfg_data_i;
        CFG_INT_GAIN:  int_gain_q  <= cfg_data_i[15:0];
        CFG_PROP_GAIN: prop_gain_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Filter state, covariance and divider control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      spd_q    <= '0;
      bi_q     <= '0;
      bs_q     <= '0;
      cov_q[0] <= 32'sd32768;
      cov_q[1] <= 32'sd16384;
      cov_q[2] <= 32'sd16384;
      cov_q[3] <= 32'sd32768;
      dcnt_q   <= '0;
      ov_q     <= 1'b0;
      hvalid_q <= '0;
      wp_q     <= '0;
      sp_q     <= '0;
      phase_q  <= 1'b0;
    end else begin
      case (op_i)
        OP_LOAD: ov_q <= observation_valid_i;
        OP_W3: begin
          pos_q <= sat32(66'(pos_q) + 66'(a_q) + 66'(p_q >>> 17));
          spd_q <= sat32(66'(spd_q) + 66'(dv_q));
        end
        OP_DSTART: dcnt_q <= DIV_STEPS;
        OP_DIV: begin
          if (dcnt_q != 6'd0) begin
            dcnt_q <= dcnt_q - 6'd1;
          end
        end
        OP_M8:  pos_q <= sat32(66'(pos_q) + 66'(pq));
        OP_M9:  spd_q <= sat32(66'(spd_q) + 66'(pq));
        OP_M10: begin
          if ((33'(bi_q) + 33'(pq)) > BIAS_LIMIT) begin
            bi_q <= 32'(BIAS_LIMIT);
          end else if ((33'(bi_q) + 33'(pq)) < -BIAS_LIMIT) begin
            bi_q <= 32'(-BIAS_LIMIT);
          end else begin
            bi_q <= 32'(33'(bi_q) + 33'(pq));
          end
        end
        OP_M11: bs_q     <= sat32(66'(pq) + 66'(bi_q));
        OP_M12: cov_q[0] <= sat32(66'(t0_q) - 66'(pq));
        OP_M13: cov_q[1] <= sat32(66'(c_q) - 66'(pq));
        OP_M14: cov_q[2] <= sat32(66'(t2_q) - 66'(pq));
        OP_W14: cov_q[3] <= sat32(66'(t3_q) - 66'(pq));
        OP_DONE: begin
          hvalid_q[wp_q] <= 1'b1;
          wp_q           <= wp_nx;
          phase_q        <= !phase_q;
          if (phase_q) begin
            sp_q <= sp_nx;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers, divider shift registers and result register
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        acc_q   <= accel_drive_i;
        dt_q    <= step_time_i;
        obs_q   <= observation_i;
        noise_q <= (measurement_noise_i > NOISE_MAX) ? NOISE_MAX : measurement_noise_i;
        hvld_q  <= hvalid_q[raddr];
      end
      OP_ACC: begin
        cor_q <= sat32(66'(bs_q) + 66'(acc_q));
        z_q   <= sat32(66'(obs_q) - 66'(hvld_q ? hrd_q : 32'sd0));
      end
      OP_M2: dv_q <= pq;
      OP_M3: a_q  <= pq;
      OP_M5: begin
        c_q  <= sat32(66'(cov_q[1]) + 66'(pq));
        t2_q <= sat32(66'(cov_q[2]) + 66'(pq));
        t3_q <= sat32(66'(cov_q[3]) + 66'($signed({8'd0, spd_noise_q})));
      end
      OP_M6: m2_q <= pq;
      OP_W6: t0_q <= sat32(66'(cov_q[0]) + 66'(m2_q) + 66'(pq)
                           + 66'($signed({8'd0, pos_noise_q})));
      OP_DSTART: begin
        num0_q  <= {(t0_q[31] ? 32'(-t0_q) : 32'(t0_q)), 16'd0};
        num1_q  <= {(t2_q[31] ? 32'(-t2_q) : 32'(t2_q)), 16'd0};
        den_q   <= s_w[33] ? 34'(-s_w) : 34'(s_w);
        neg0_q  <= t0_q[31] ^ s_w[33];
        neg1_q  <= t2_q[31] ^ s_w[33];
        szero_q <= (s_w == 34'sd0);
        rem0_q  <= '0;
        rem1_q  <= '0;
      end
      OP_DIV: begin
        if (dcnt_q != 6'd0) begin
          rem0_q <= ge0 ? trial0 - {1'b0, den_q} : trial0;
          rem1_q <= ge1 ? trial1 - {1'b0, den_q} : trial1;
          num0_q <= {num0_q[46:0], ge0};
          num1_q <= {num1_q[46:0], ge1};
        end
      end
      OP_DFIN: begin
        k0_q <= qsat(num0_q, neg0_q, szero_q);
        k1_q <= qsat(num1_q, neg1_q, szero_q);
      end
      OP_DONE: begin
        position_o         <= pos_q;
        speed_o            <= spd_q;
        corrected_accel_o  <= cor_q;
        bias_total_o       <= bs_q;
        observation_used_o <= ov_q;
      end
      default: ;
    endcase
  end

  // Position history memory: read at the delayed entry, push the newest
  always_ff @(posedge clk_i) begin
    if (op_i == OP_LOAD) begin
      hrd_q <= hmem[raddr];
    end
    if (op_i == OP_DONE) begin
      hmem[wp_q] <= pos_q;
    end
  end

  // Speed history memory: advance every second tick, always rewrite the newest
  always_ff @(posedge clk_i) begin
    if (op_i == OP_DONE) begin
      if (phase_q) begin
        smem[sp_nx] <= spd_q;
      end else begin
        smem[sp_q] <= spd_q;
      end
    end
  end

endmodule

@@ rtl/altitude_kalman_estimator.sv @@
// Top level of the two-state altitude estimator.
//
// Input channel: in_valid_i / in_stall_o with the tick fields. A request is
// taken when valid is high and stall is low; stall stays high while a tick is
// worked on. Output channel: out_valid_o / out_stall_i, one result per tick.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high, writes belong between ticks.
// With an observation the tick also runs the 48-step restoring divider that
// forms both gains. The next request is taken in the cycle after the result
// is written; a new tick is not taken until the previous one is through.
// All multiplies go through one 32x32 multiplier, so one tick is in flight.
// A finished result waits in an output register; the next tick is accepted
// meanwhile, and only its final write waits while out_stall_i is high.
// Reset clears position, speed, biases and history valid bits, loads the
// initial covariance and the default register values.
module altitude_kalman_estimator
  import ake_pkg::*;
#(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] accel_drive_i,
  input  logic [15:0]        step_time_i,
  input  logic signed [31:0] observation_i,
  input  logic [3:0]         delay_index_i,
  input  logic               observation_valid_i,
  input  logic [26:0]        measurement_noise_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] position_o,
  output logic signed [31:0] speed_o,
  output logic signed [31:0] corrected_accel_o,
  output logic signed [31:0] bias_total_o,
  output logic               observation_used_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i
);

  dp_op_e     op;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  ake_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .op_o        (op)
  );

  ake_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .op_i                (op),
    .status_o            (status),
    .cfg_we_i            (cfg_valid_i && cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .accel_drive_i       (accel_drive_i),
    .step_time_i         (step_time_i),
    .observation_i       (observation_i),
    .delay_index_i       (delay_index_i),
    .observation_valid_i (observation_valid_i),
    .measurement_noise_i (measurement_noise_i),
    .position_o          (position_o),
    .speed_o             (speed_o),
    .corrected_accel_o   (corrected_accel_o),
    .bias_total_o        (bias_total_o),
    .observation_used_o  (observation_used_o)
  );

endmodule

@@ rtl/ake_checker.sv @@
// Port-level checks for the altitude estimator, bound to the top level.
module ake_port_props (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] position_o
);

  // A held result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");

  // A held result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(position_o)) else $error("result changed");

  // An accepted request keeps the block busy next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("request not held busy");

  // A new result only appears at the end of a tick's work
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o)) else $error("result without work");

endmodule

bind altitude_kalman_estimator ake_port_props u_ake_port_props (.*);

@@ tb/sv/ake_checker.sv @@
// Checker for the altitude estimator: watches the tick and config channels and compares results.
module ake_checker
  import ake_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] accel_drive_i,
  input  logic [15:0]        step_time_i,
  input  logic signed [31:0] observation_i,
  input  logic [3:0]         delay_index_i,
  input  logic               observation_valid_i,
  input  logic [26:0]        measurement_noise_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] position_i,
  input  logic signed [31:0] speed_i,
  input  logic signed [31:0] corrected_accel_i,
  input  logic signed [31:0] bias_total_i,
  input  logic               observation_used_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] speed;
    logic signed [31:0] corrected_accel;
    logic signed [31:0] bias_total;
    logic               observation_used;
  } estimate_t;

  localparam int DEPTH = 16;
  localparam longint Q_ONE = 65536;
  localparam longint NOISE_CEIL = 64'd98304000;
  localparam longint BIAS_CEIL = 64'd6553600;

  estimate_t estimate_q[$];

  longint pos_noise, spd_noise, int_gain, prop_gain;
  longint pos_est, spd_est, bias_int, bias_acc;
  longint cov[4];
  longint pos_hist[DEPTH];
  bit     spd_phase;

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Arithmetic shift on longint floors toward minus infinity
  function automatic longint qmul(longint a, longint b);
    return clip32((a * b) >>> 16);
  endfunction

  function automatic longint kgain(longint t, longint s);
    if (s == 0) return 0;
    return clip32((t * Q_ONE) / s);
  endfunction

  task automatic reset_filter();
    pos_noise = 328; spd_noise = 6554; int_gain = 1638; prop_gain = 1966;
    pos_est = 0; spd_est = 0; bias_int = 0; bias_acc = 0;
    cov[0] = 32768; cov[1] = 16384; cov[2] = 16384; cov[3] = 32768;
    foreach (pos_hist[i]) pos_hist[i] = 0;
    spd_phase = 0;
  endtask

  // Advance the filter by one tick and queue its estimate
  task automatic predict_tick();
    longint accel, dt, obs, noise, corr, dv, dp;
    longint c, t0, t1, t2, t3, s, k0, k1, z;
    estimate_t e;
    accel = longint'(accel_drive_i);
    dt = longint'(step_time_i);
    obs = longint'(observation_i);
    noise = longint'(measurement_noise_i);
    if (noise > NOISE_CEIL) noise = NOISE_CEIL;
    corr = clip32(bias_acc + accel);
    dv = qmul(corr, dt);
    dp = qmul(spd_est, dt) + ((dv * dt) >>> 17);
    pos_est = clip32(pos_est + dp);
    spd_est = clip32(spd_est + dv);
    if (observation_valid_i) begin
      c = clip32(cov[1] + qmul(cov[3], 6554));
      t0 = clip32(cov[0] + qmul(cov[2], 6554) + qmul(c, 6554) + pos_noise);
      t1 = c;
      t2 = clip32(cov[2] + qmul(cov[3], 6554));
      t3 = clip32(cov[3] + spd_noise);
      s = t0 + noise;
      k0 = kgain(t0, s);
      k1 = kgain(t2, s);
      z = clip32(obs - pos_hist[delay_index_i]);
      pos_est = clip32(pos_est + qmul(k0, z));
      spd_est = clip32(spd_est + qmul(k1, z));
      bias_int = bias_int + qmul(int_gain, z);
      if (bias_int > BIAS_CEIL) bias_int = BIAS_CEIL;
      if (bias_int < -BIAS_CEIL) bias_int = -BIAS_CEIL;
      bias_acc = clip32(qmul(prop_gain, z) + bias_int);
      cov[0] = clip32(t0 - qmul(k0, t0));
      cov[1] = clip32(t1 - qmul(k0, t1));
      cov[2] = clip32(t2 - qmul(k1, t0));
      cov[3] = clip32(t3 - qmul(k1, t1));
    end
    for (int i = DEPTH - 1; i > 0; i--) pos_hist[i] = pos_hist[i - 1];
    pos_hist[0] = pos_est;
    spd_phase = !spd_phase;
    e.position = pos_est[31:0];
    e.speed = spd_est[31:0];
    e.corrected_accel = corr[31:0];
    e.bias_total = bias_acc[31:0];
    e.observation_used = observation_valid_i;
    estimate_q.push_back(e);
  endtask

  task automatic report(string what, estimate_t exp_e, estimate_t act_e);
    fail_count_o++;
    if (fail_count_o <= 10)
      $display("mismatch %s: expected pos %0d spd %0d acc %0d bias %0d used %0b, %s",
               what, exp_e.position, exp_e.speed, exp_e.corrected_accel,
               exp_e.bias_total, exp_e.observation_used,
               $sformatf("got %0d %0d %0d %0d %0b", act_e.position, act_e.speed,
                         act_e.corrected_accel, act_e.bias_total,
                         act_e.observation_used));
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    reset_filter();
  end

  // Track config writes, predict requests, compare results
  always @(posedge clk_i) begin
    estimate_t act_e, exp_e;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_POS_NOISE: pos_noise = longint'(cfg_data_i);
          CFG_SPD_NOISE: spd_noise = longint'(cfg_data_i);
          CFG_INT_GAIN:  int_gain = longint'(cfg_data_i[15:0]);
          CFG_PROP_GAIN: prop_gain = longint'(cfg_data_i[15:0]);
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_tick();
      if (out_valid_i && !out_stall_i) begin
        act_e = '{position_i, speed_i, corrected_accel_i, bias_total_i, observation_used_i};
        if (estimate_q.size() == 0) begin
          exp_e = '0;
          report("unexpected result", exp_e, act_e);
        end else begin
          exp_e = estimate_q.pop_front();
          if (exp_e != act_e) report("field", exp_e, act_e);
        end
      end
      pending_o = estimate_q.size();
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the altitude estimator testbench: stimulus, config phases and verdict.
module testbench
  import ake_pkg::*;
;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid_i = 0;
  logic               in_stall_o;
  logic signed [31:0] accel_drive_i = 0;
  logic [15:0]        step_time_i = 0;
  logic signed [31:0] observation_i = 0;
  logic [3:0]         delay_index_i = 0;
  logic               observation_valid_i = 0;
  logic [26:0]        measurement_noise_i = 0;
  logic               out_valid_o;
  logic               out_stall_i = 0;
  logic signed [31:0] position_o, speed_o, corrected_accel_o, bias_total_o;
  logic               observation_used_o;
  logic               cfg_valid_i = 0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = 0;
  logic [23:0]        cfg_data_i = 0;
  int                 fail_count, pending, cycle_count = 0;
  bit                 stall_free = 0;

  altitude_kalman_estimator dut (.*);

  ake_checker checker_inst (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .accel_drive_i, .step_time_i,
    .observation_i, .delay_index_i, .observation_valid_i, .measurement_noise_i,
    .out_valid_i(out_valid_o), .out_stall_i, .position_i(position_o), .speed_i(speed_o),
    .corrected_accel_i(corrected_accel_o), .bias_total_i(bias_total_o),
    .observation_used_i(observation_used_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  // Stall the result side on its own pattern, with quiet stretches
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (stall_free || (cycle_count % 4000) < 600) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 2) == 0);
    if (cycle_count > 900000) begin
      $display("altitude_kalman_estimator test failed");
      $finish;
    end
  end

  task automatic send_tick(logic signed [31:0] acc, logic [15:0] dt, logic signed [31:0] obs,
                           logic [3:0] dly, logic vld, logic [26:0] noise);
    in_valid_i <= 1'b1;
    accel_drive_i <= acc;
    step_time_i <= dt;
    observation_i <= obs;
    delay_index_i <= dly;
    observation_valid_i <= vld;
    measurement_noise_i <= noise;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic idle_gap(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for the result queue to drain, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic random_tick();
    logic signed [31:0] acc, obs;
    logic [26:0]        noise;
    logic [15:0]        dt;
    int                 sel;
    sel = $urandom_range(0, 9);
    acc = (sel == 0) ? $signed($urandom)
                     : $signed($urandom_range(0, 2000000)) - 32'sd1000000;
    obs = (sel == 1) ? $signed($urandom)
                     : $signed($urandom_range(0, 40000000)) - 32'sd20000000;
    dt = (sel == 2) ? 16'($urandom) : 16'($urandom_range(0, 2000));
    noise = (sel == 3) ? 27'($urandom) : 27'($urandom_range(0, 98304000));
    send_tick(acc, dt, obs, 4'($urandom), $urandom_range(0, 2) != 0, noise);
  endtask

  initial begin
    int left, burst;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: extremes and special cases on reset settings
    send_tick(32'sh7fffffff, 16'hffff, 32'sh7fffffff, 4'd0, 1'b1, 27'd0);
    send_tick(32'sh80000000, 16'hffff, 32'sh80000000, 4'd15, 1'b1, 27'h7ffffff);
    send_tick(32'sd0, 16'd0, 32'sd0, 4'd3, 1'b0, 27'd98304000);
    send_tick(32'sh00010000, 16'd655, 32'sh80000000, 4'd15, 1'b1, 27'd98304001);
    send_tick(-32'sh00010000, 16'd655, 32'sh7fffffff, 4'd7, 1'b1, 27'd65536);
    for (int i = 0; i < 8; i++)
      send_tick(32'sh00640000, 16'd6554, 32'sh01000000, 4'(i), 1'b1, 27'd100);
    drain();
    // Zero-variance case: zero covariance noise and zero measurement noise
    write_reg(CFG_POS_NOISE, 24'd0);
    write_reg(CFG_SPD_NOISE, 24'd0);
    write_reg(CFG_INT_GAIN, 24'hffff);
    write_reg(CFG_PROP_GAIN, 24'hffff);
    send_tick(32'sd0, 16'd100, 32'sh00050000, 4'd2, 1'b1, 27'd0);
    send_tick(32'sh12345678, 16'hffff, 32'sh80000001, 4'd1, 1'b1, 27'd0);
    for (int i = 0; i < 6; i++)
      send_tick(32'sd0, 16'd0, 32'sd0, 4'd0, 1'b1, 27'd0);
    drain();
    // Random phases across several register settings
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_POS_NOISE, 24'hffffff); write_reg(CFG_SPD_NOISE, 24'hffffff);
          write_reg(CFG_INT_GAIN, 24'd0); write_reg(CFG_PROP_GAIN, 24'd0);
        end
        1: begin
          write_reg(CFG_POS_NOISE, 24'd328); write_reg(CFG_SPD_NOISE, 24'd6554);
          write_reg(CFG_INT_GAIN, 24'd1638); write_reg(CFG_PROP_GAIN, 24'd1966);
        end
        default: begin
          write_reg(CFG_POS_NOISE, 24'($urandom)); write_reg(CFG_SPD_NOISE, 24'($urandom));
          write_reg(CFG_INT_GAIN, 24'($urandom)); write_reg(CFG_PROP_GAIN, 24'($urandom));
        end
      endcase
      stall_free = (phase == 1);
      left = 160;
      while (left > 0) begin
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst && left > 0; k++) begin
          random_tick();
          left--;
        end
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 40));
      end
      drain();
    end
    if (fail_count == 0) $display("altitude_kalman_estimator test passed");
    else $display("altitude_kalman_estimator test failed");
    $finish;
  end

endmodule
